// File: src/nfea_pkg.sv
// shared types and constants for the next fit extent allocator
package nfea_pkg;
  localparam int MAX_EXTENTS = 64;
  localparam int ADDR_BITS = 16;
  localparam int LEN_BITS = ADDR_BITS + 1;
  localparam int IDX_BITS = $clog2(MAX_EXTENTS);
  localparam int CNT_BITS = $clog2(MAX_EXTENTS + 1);

  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  localparam logic [0:0] REG_POOL_BASE = 1'd0;
  localparam logic [0:0] REG_POOL_SIZE = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_UPDATE,
    ST_SHIFT,
    ST_DONE
  } state_t;

  // table operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_NONE,
    OP_INIT,
    OP_WRITE,
    OP_REMOVE,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [IDX_BITS-1:0]  idx;
    logic [ADDR_BITS-1:0] start;
    logic [LEN_BITS-1:0]  length;
  } cell_cmd_t;
endpackage

// File: src/nfea_cell.sv
// one table entry: holds an extent and shifts with its neighbors
module nfea_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [nfea_pkg::IDX_BITS-1:0]         my_idx,
  input  nfea_pkg::cell_cmd_t                   cmd,
  input  logic [nfea_pkg::ADDR_BITS-1:0]        left_start,
  input  logic [nfea_pkg::LEN_BITS-1:0]         left_length,
  input  logic [nfea_pkg::ADDR_BITS-1:0]        right_start,
  input  logic [nfea_pkg::LEN_BITS-1:0]         right_length,
  output logic [nfea_pkg::ADDR_BITS-1:0]        start,
  output logic [nfea_pkg::LEN_BITS-1:0]         length
);
  logic [nfea_pkg::ADDR_BITS-1:0] start_next;
  logic [nfea_pkg::LEN_BITS-1:0]  length_next;

  // entry update per broadcast op
  always_comb begin
    start_next = start;
    length_next = length;
    case (cmd.op)
      nfea_pkg::OP_INIT: begin
        start_next = (my_idx == '0) ? cmd.start : '0;
        length_next = (my_idx == '0) ? cmd.length : '0;
      end
      nfea_pkg::OP_WRITE: begin
        if (my_idx == cmd.idx) begin
          start_next = cmd.start;
          length_next = cmd.length;
        end
      end
      nfea_pkg::OP_REMOVE: begin
        if (my_idx >= cmd.idx) begin
          start_next = right_start;
          length_next = right_length;
        end
      end
      nfea_pkg::OP_INSERT: begin
        if (my_idx == cmd.idx) begin
          start_next = cmd.start;
          length_next = cmd.length;
        end else if (my_idx > cmd.idx) begin
          start_next = left_start;
          length_next = left_length;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= '0;
      length <= '0;
    end else begin
      start <= start_next;
      length <= length_next;
    end
  end
endmodule

// File: src/nfea_ctrl.sv
// request sequencer: search, decide and drive the cell row
module nfea_ctrl (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     init_req,
  input  logic [nfea_pkg::ADDR_BITS-1:0]           init_start,
  input  logic [nfea_pkg::LEN_BITS-1:0]            init_length,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     in_type,
  input  logic [nfea_pkg::LEN_BITS-1:0]            in_size,
  input  logic [nfea_pkg::ADDR_BITS-1:0]           in_addr,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [nfea_pkg::ADDR_BITS-1:0]           out_addr,
  output logic [1:0]                               out_status,
  input  logic [nfea_pkg::MAX_EXTENTS-1:0][nfea_pkg::ADDR_BITS-1:0] ent_start,
  input  logic [nfea_pkg::MAX_EXTENTS-1:0][nfea_pkg::LEN_BITS-1:0]  ent_length,
  output nfea_pkg::cell_cmd_t                      cmd
);
  localparam int N = nfea_pkg::MAX_EXTENTS;
  localparam int AB = nfea_pkg::ADDR_BITS;
  localparam int LB = nfea_pkg::LEN_BITS;
  localparam int IB = nfea_pkg::IDX_BITS;
  localparam int CB = nfea_pkg::CNT_BITS;
  localparam logic [LB:0] SPAN = {2'b01, {AB{1'b0}}};

  nfea_pkg::state_t state, state_next;
  logic [CB-1:0] count;
  logic [IB-1:0] rover;
  logic          req_type;
  logic [LB-1:0] req_size;
  logic [AB-1:0] req_addr;
  logic [N-1:0]  fit_vec, below_vec;
  logic [AB-1:0] res_addr;
  logic [1:0]    res_status;
  // decision registers (the merge flags are combinational)
  logic          hit;
  logic [IB-1:0] hit_idx;
  logic [CB-1:0] k_pos;
  logic          lo_merge, up_merge;
  logic          shift_pending;
  nfea_pkg::cell_cmd_t shift_cmd;

  // per-cell compares against the held request (parallel)
  always_comb begin
    for (int i = 0; i < N; i++) begin
      fit_vec[i] = (i < count) && (ent_length[i] >= req_size);
      below_vec[i] = (i < count) && (ent_start[i] <= req_addr);
    end
  end

  // next-fit pick: first fit at or after the rover, else first overall
  logic [N-1:0] fit_hi;
  logic         f_hi_any, f_any;
  logic [IB-1:0] f_hi_idx, f_idx;
  logic [CB-1:0] k_cnt;
  always_comb begin
    f_hi_any = 1'b0;
    f_any = 1'b0;
    f_hi_idx = '0;
    f_idx = '0;
    k_cnt = count;
    for (int i = N - 1; i >= 0; i--) begin
      fit_hi[i] = fit_vec[i] && (IB'(i) >= rover);
      if (fit_hi[i]) begin
        f_hi_any = 1'b1;
        f_hi_idx = IB'(i);
      end
      if (fit_vec[i]) begin
        f_any = 1'b1;
        f_idx = IB'(i);
      end
    end
    // insertion point: first entry starting above the address
    for (int i = N - 1; i >= 0; i--) begin
      if ((i < count) && !below_vec[i]) k_cnt = CB'(i);
    end
  end

  // clipped free length
  logic [LB:0] room;
  logic [LB-1:0] free_len;
  always_comb begin
    room = SPAN - {{(LB + 1 - AB){1'b0}}, req_addr};
    free_len = ({1'b0, req_size} > room) ? room[LB-1:0] : req_size;
  end

  logic [IB-1:0] kidx, km1;
  logic [LB:0]   lo_end;
  logic [LB:0]   up_end;
  always_comb begin
    kidx = k_pos[IB-1:0];
    km1 = kidx - 1'b1;
    lo_end = {1'b0, ent_length[km1]} + {{(LB + 1 - AB){1'b0}}, ent_start[km1]};
    up_end = {1'b0, free_len} + {{(LB + 1 - AB){1'b0}}, req_addr};
  end

  // neighbor merge checks for a free
  always_comb begin
    lo_merge = (k_pos != '0) && (lo_end == {1'b0, {(LB - AB){1'b0}}, req_addr});
    up_merge = (k_pos < count) && (up_end == {{(LB + 1 - AB){1'b0}}, ent_start[kidx]});
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      nfea_pkg::ST_IDLE:   if (in_valid && in_ready) state_next = nfea_pkg::ST_EVAL;
      nfea_pkg::ST_EVAL:   state_next = nfea_pkg::ST_UPDATE;
      nfea_pkg::ST_UPDATE: state_next = nfea_pkg::ST_SHIFT;
      nfea_pkg::ST_SHIFT:  state_next = nfea_pkg::ST_DONE;
      nfea_pkg::ST_DONE:   if (out_ready) state_next = nfea_pkg::ST_IDLE;
      default:             state_next = nfea_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state == nfea_pkg::ST_IDLE) && !init_req;
    out_valid = (state == nfea_pkg::ST_DONE);
    out_addr = res_addr;
    out_status = res_status;
  end

  logic [LB-1:0] cur_len;
  logic [AB-1:0] cur_start;
  logic [LB-1:0] rem_len;
  always_comb begin
    cur_len = ent_length[hit_idx];
    cur_start = ent_start[hit_idx];
    rem_len = cur_len - req_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfea_pkg::ST_IDLE;
      count <= CB'(1);
      rover <= '0;
      cmd <= '{op: nfea_pkg::OP_INIT, idx: '0, start: '0, length: LB'(1000)};
      shift_pending <= 1'b0;
      shift_cmd <= '0;
      hit <= 1'b0;
      hit_idx <= '0;
      k_pos <= '0;
      res_addr <= '0;
      res_status <= nfea_pkg::STATUS_OK;
      req_type <= 1'b0;
      req_size <= '0;
      req_addr <= '0;
    end else begin
      state <= state_next;
      cmd <= '0;
      if (init_req) begin
        cmd <= '{op: nfea_pkg::OP_INIT, idx: '0, start: init_start, length: init_length};
        count <= (init_length == '0) ? '0 : CB'(1);
        rover <= '0;
      end
      case (state)
        nfea_pkg::ST_IDLE: begin
          if (in_valid && in_ready) begin
            req_type <= in_type;
            req_size <= in_size;
            req_addr <= in_addr;
          end
        end
        nfea_pkg::ST_EVAL: begin
          hit <= f_hi_any || f_any;
          hit_idx <= f_hi_any ? f_hi_idx : f_idx;
          k_pos <= k_cnt;
          if ({1'b0, rover} >= count && count != '0) rover <= '0;
        end
        nfea_pkg::ST_UPDATE: begin
          res_addr <= '0;
          res_status <= nfea_pkg::STATUS_OK;
          shift_pending <= 1'b0;
          if (req_type == nfea_pkg::REQ_ALLOC) begin
            if (count == '0 || !hit) begin
              res_status <= nfea_pkg::STATUS_NO_FIT;
            end else begin
              res_addr <= cur_start;
              if (rem_len == '0) begin
                cmd <= '{op: nfea_pkg::OP_REMOVE, idx: hit_idx, start: '0, length: '0};
                count <= count - 1'b1;
                rover <= ({1'b0, hit_idx} + 1'b1 < {1'b0, count}) ? hit_idx : '0;
              end else begin
                cmd <= '{op: nfea_pkg::OP_WRITE, idx: hit_idx,
                         start: cur_start + req_size[AB-1:0], length: rem_len};
                rover <= ({1'b0, hit_idx} + 1'b1 < {1'b0, count}) ? hit_idx + 1'b1 : '0;
              end
            end
          end else if (free_len != '0) begin
            if (lo_merge && up_merge) begin
              cmd <= '{op: nfea_pkg::OP_WRITE, idx: km1, start: ent_start[km1],
                       length: ent_length[km1] + free_len + ent_length[kidx]};
              shift_pending <= 1'b1;
              shift_cmd <= '{op: nfea_pkg::OP_REMOVE, idx: kidx, start: '0, length: '0};
              count <= count - 1'b1;
              if ({1'b0, rover} > k_pos) begin
                if ({1'b0, rover} - 1'b1 >= count - 1'b1) rover <= '0;
                else rover <= rover - 1'b1;
              end else if ({1'b0, rover} >= count - 1'b1) rover <= '0;
            end else if (lo_merge) begin
              cmd <= '{op: nfea_pkg::OP_WRITE, idx: km1, start: ent_start[km1],
                       length: ent_length[km1] + free_len};
            end else if (up_merge) begin
              cmd <= '{op: nfea_pkg::OP_WRITE, idx: kidx, start: req_addr,
                       length: ent_length[kidx] + free_len};
            end else if (count >= CB'(N)) begin
              res_status <= nfea_pkg::STATUS_FULL;
            end else begin
              cmd <= '{op: nfea_pkg::OP_INSERT, idx: kidx, start: req_addr, length: free_len};
              count <= count + 1'b1;
              if (count == '0) rover <= '0;
              else if ({1'b0, rover} >= k_pos) rover <= rover + 1'b1;
            end
          end
        end
        nfea_pkg::ST_SHIFT: begin
          if (shift_pending) cmd <= shift_cmd;
          shift_pending <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CB'(N)) else $error("extent count above table size");
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != nfea_pkg::ST_IDLE |-> !in_ready) else $error("took a request while busy");
  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != nfea_pkg::STATUS_OK |-> out_addr == '0)
    else $error("address on failed request");
endmodule

// File: src/next_fit_extent_allocator_unit.sv
// Next fit extent allocator with coalescing free, top level.
// A request passes through compare and pick, update, shift and result in turn.
// A new request is taken only once the last result is accepted; all 64 cells shift on one command.
// Reset (rst, synchronous): pool 0..999 as one extent, rover 0.
// A configuration write sets init_req, which issues an init command that rebuilds the table.
module next_fit_extent_allocator_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // block_size[16:0], block_address[32:17], zero fill
  input  logic        s_tuser,  // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // alloc_address[15:0], status[17:16], zero fill
);
  localparam int N = nfea_pkg::MAX_EXTENTS;
  localparam int AB = nfea_pkg::ADDR_BITS;
  localparam int LB = nfea_pkg::LEN_BITS;

  logic [AB-1:0] pool_base;
  logic [LB-1:0] pool_size;
  logic          init_req;
  logic [LB:0]   room;
  logic [LB-1:0] init_len;
  logic [N-1:0][AB-1:0] ent_start;
  logic [N-1:0][LB-1:0] ent_length;
  nfea_pkg::cell_cmd_t  cmd;
  logic [AB-1:0] out_addr;
  logic [1:0]    out_status;
  logic          wr;

  // config registers
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= '0;
      pool_size <= LB'(1000);
      init_req <= 1'b0;
    end else begin
      init_req <= wr && (paddr[2] == nfea_pkg::REG_POOL_BASE ||
                         paddr[2] == nfea_pkg::REG_POOL_SIZE) && paddr[1:0] == 2'b00;
      if (wr && paddr[1:0] == 2'b00) begin
        if (paddr[2] == nfea_pkg::REG_POOL_BASE) pool_base <= pwdata[AB-1:0];
        else pool_size <= pwdata[LB-1:0];
      end
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == 3'd0) prdata = {{(32 - AB){1'b0}}, pool_base};
    else if (paddr == 3'd4) prdata = {{(32 - LB){1'b0}}, pool_size};
  end

  // pool clipped to the address top
  always_comb begin
    room = {2'b01, {AB{1'b0}}} - {{(LB + 1 - AB){1'b0}}, pool_base};
    init_len = ({1'b0, pool_size} > room) ? room[LB-1:0] : pool_size;
  end

  // row of cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    nfea_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .my_idx      (nfea_pkg::IDX_BITS'(i)),
      .cmd         (cmd),
      .left_start  ((i == 0) ? '0 : ent_start[(i == 0) ? 0 : i - 1]),
      .left_length ((i == 0) ? '0 : ent_length[(i == 0) ? 0 : i - 1]),
      .right_start ((i == N - 1) ? '0 : ent_start[(i == N - 1) ? i : i + 1]),
      .right_length((i == N - 1) ? '0 : ent_length[(i == N - 1) ? i : i + 1]),
      .start       (ent_start[i]),
      .length      (ent_length[i])
    );
  end

  nfea_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .init_req   (init_req),
    .init_start (pool_base),
    .init_length(init_len),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_type    (s_tuser),
    .in_size    (s_tdata[16:0]),
    .in_addr    (s_tdata[32:17]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_addr   (out_addr),
    .out_status (out_status),
    .ent_start  (ent_start),
    .ent_length (ent_length),
    .cmd        (cmd)
  );

  assign m_tdata = {6'd0, out_status, out_addr};
endmodule

// File: tb/next_fit_extent_allocator_unit_checker.sv
// request and result monitor with extent table prediction for the extent allocator
`timescale 1ns / 1ps
module next_fit_extent_allocator_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [39:0] s_tdata,  // block_size[16:0], block_address[32:17], zero fill
  input  logic        s_tuser,  // req_type
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,  // alloc_address[15:0], status[17:16], zero fill
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [nfea_pkg::ADDR_BITS-1:0] addr;
    logic [1:0]                     status;
  } grant_t;

  localparam longint SPAN = longint'(1) << nfea_pkg::ADDR_BITS;

  longint ext_base[nfea_pkg::MAX_EXTENTS];
  longint ext_len[nfea_pkg::MAX_EXTENTS];
  int     ext_num;
  int     rover;
  longint cfg_base;
  longint cfg_size;
  grant_t grant_q[$];

  assign pending = grant_q.size();

  // rebuild the table from the pool registers
  function automatic void rebuild();
    longint len;
    len = cfg_size;
    for (int i = 0; i < nfea_pkg::MAX_EXTENTS; i++) begin
      ext_base[i] = 0;
      ext_len[i] = 0;
    end
    if (len > SPAN - cfg_base) len = SPAN - cfg_base;
    rover = 0;
    ext_num = 0;
    if (len != 0) begin
      ext_base[0] = cfg_base;
      ext_len[0] = len;
      ext_num = 1;
    end
  endfunction

  function automatic void drop_extent(int j);
    for (int i = j; i + 1 < ext_num; i++) begin
      ext_base[i] = ext_base[i+1];
      ext_len[i] = ext_len[i+1];
    end
    ext_num--;
    ext_base[ext_num] = 0;
    ext_len[ext_num] = 0;
  endfunction

  // next fit allocation from the rover
  function automatic grant_t carve(longint size);
    grant_t g;
    int j;
    g.addr = '0;
    g.status = nfea_pkg::STATUS_NO_FIT;
    if (ext_num == 0) return g;
    if (rover >= ext_num) rover = 0;
    for (int n = 0; n < ext_num; n++) begin
      j = (rover + n) % ext_num;
      if (ext_len[j] >= size) begin
        g.addr = ext_base[j][nfea_pkg::ADDR_BITS-1:0];
        g.status = nfea_pkg::STATUS_OK;
        ext_base[j] += size;
        ext_len[j] -= size;
        if (ext_len[j] == 0) begin
          drop_extent(j);
          rover = (j < ext_num) ? j : 0;
        end else begin
          rover = (j + 1 < ext_num) ? j + 1 : 0;
        end
        return g;
      end
    end
    return g;
  endfunction

  // coalescing free, sorted insert otherwise
  function automatic logic [1:0] give_back(longint size, longint addr);
    int k;
    bit lo, hi;
    k = 0;
    if (size > SPAN - addr) size = SPAN - addr;
    if (size == 0) return nfea_pkg::STATUS_OK;
    while (k < ext_num && ext_base[k] <= addr) k++;
    lo = k > 0 && ext_base[k-1] + ext_len[k-1] == addr;
    hi = k < ext_num && addr + size == ext_base[k];
    if (lo && hi) begin
      ext_len[k-1] += size + ext_len[k];
      drop_extent(k);
      if (rover > k) rover--;
      if (rover >= ext_num) rover = 0;
    end else if (lo) begin
      ext_len[k-1] += size;
    end else if (hi) begin
      ext_base[k] = addr;
      ext_len[k] += size;
    end else begin
      if (ext_num >= nfea_pkg::MAX_EXTENTS) return nfea_pkg::STATUS_FULL;
      if (ext_num == 0) rover = 0;
      else if (rover >= k) rover++;
      for (int i = ext_num; i > k; i--) begin
        ext_base[i] = ext_base[i-1];
        ext_len[i] = ext_len[i-1];
      end
      ext_base[k] = addr;
      ext_len[k] = size;
      ext_num++;
    end
    return nfea_pkg::STATUS_OK;
  endfunction

  // watch config writes, requests and results
  always @(posedge clk) begin
    grant_t g, got;
    int errs;
    errs = 0;
    if (rst) begin
      cfg_base = 0;
      cfg_size = 1000;
      rebuild();
      grant_q.delete();
      fail_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == nfea_pkg::REG_POOL_BASE) cfg_base = pwdata[15:0];
        else cfg_size = pwdata[16:0];
        rebuild();
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == nfea_pkg::REQ_ALLOC) begin
          g = carve(s_tdata[16:0]);
        end else begin
          g.addr = '0;
          g.status = give_back(s_tdata[16:0], s_tdata[32:17]);
        end
        grant_q.push_back(g);
      end
      if (m_tvalid && m_tready) begin
        got.addr = m_tdata[15:0];
        got.status = m_tdata[17:16];
        if (grant_q.size() == 0) begin
          $error("unexpected result addr=%0d status=%0d", got.addr, got.status);
          errs++;
        end else begin
          g = grant_q.pop_front();
          if (got.addr !== g.addr) begin
            $error("alloc_address expected %0d actual %0d", g.addr, got.addr);
            errs++;
          end
          if (got.status !== g.status) begin
            $error("status expected %0d actual %0d", g.status, got.status);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

// File: tb/next_fit_extent_allocator_unit_test.sv
// stimulus and verdict for the next fit extent allocator
`timescale 1ns / 1ps
module next_fit_extent_allocator_unit_test;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        s_tvalid, s_tready;
  logic [39:0] s_tdata;  // block_size[16:0], block_address[32:17], zero fill
  logic        s_tuser;  // req_type
  logic        m_tvalid, m_tready;
  logic [23:0] m_tdata;  // alloc_address[15:0], status[17:16], zero fill
  int          fail_count;
  int          pending;
  int          cycles;
  bit          hold_off;
  bit          sending_done;

  next_fit_extent_allocator_unit dut (.*);
  next_fit_extent_allocator_unit_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 400000) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result side backpressure, with one long hold-off on request
  initial begin
    int w;
    m_tready <= 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        m_tready <= 0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
      if (w > 0) begin
        m_tready <= 0;
        repeat (w) @(posedge clk);
      end
      m_tready <= 1;
    end
  end

  task automatic reg_write(logic [0:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  task automatic send_request(logic kind, logic [16:0] size, logic [15:0] addr, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 7) : 0;
    if (w > 0) begin
      s_tvalid <= 0;
      repeat (w) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= kind;
    s_tdata <= {7'd0, addr, size};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // mostly small allocations, and frees mostly inside the pool range
  task automatic random_phase(int count, logic [15:0] base, int span);
    logic [16:0] sz;
    logic [15:0] ad;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      sz = 17'($urandom_range(0, 40));
      if (r < 45) begin
        if ($urandom_range(0, 20) == 0) sz = 17'($urandom);
        send_request(nfea_pkg::REQ_ALLOC, sz, 16'($urandom), 1);
      end else begin
        if (r < 85) ad = 16'(base + $urandom_range(0, span));
        else ad = 16'($urandom);
        if ($urandom_range(0, 30) == 0) sz = 17'($urandom);
        send_request(nfea_pkg::REQ_FREE, sz, ad, 1);
      end
    end
  endtask

  initial begin
    rst <= 1;
    psel <= 0; penable <= 0; pwrite <= 0; paddr <= '0; pwdata <= '0;
    s_tvalid <= 0; s_tuser <= nfea_pkg::REQ_ALLOC; s_tdata <= '0;
    hold_off = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset pool 0..999
    send_request(nfea_pkg::REQ_ALLOC, 17'd0, 16'hFFFF, 0);
    send_request(nfea_pkg::REQ_ALLOC, 17'd100, 16'd0, 0);
    send_request(nfea_pkg::REQ_ALLOC, 17'd2000, 16'd0, 0);
    send_request(nfea_pkg::REQ_ALLOC, 17'd900, 16'd0, 0);
    send_request(nfea_pkg::REQ_ALLOC, 17'd1, 16'd0, 0);
    send_request(nfea_pkg::REQ_FREE, 17'd0, 16'd50, 0);
    send_request(nfea_pkg::REQ_FREE, 17'd10, 16'd200, 0);
    send_request(nfea_pkg::REQ_FREE, 17'd10, 16'd210, 0);
    send_request(nfea_pkg::REQ_FREE, 17'd10, 16'd190, 0);
    send_request(nfea_pkg::REQ_FREE, 17'd10, 16'd500, 0);
    send_request(nfea_pkg::REQ_FREE, 17'd290, 16'd220, 0);
    send_request(nfea_pkg::REQ_FREE, 17'h1FFFF, 16'hFFF0, 0);
    send_request(nfea_pkg::REQ_FREE, 17'd5, 16'd2000, 0);
    send_request(nfea_pkg::REQ_ALLOC, 17'h10000, 16'd0, 0);
    drain();

    // full table: many isolated one-unit frees
    reg_write(nfea_pkg::REG_POOL_BASE, 32'd0);
    reg_write(nfea_pkg::REG_POOL_SIZE, 32'd1);
    for (int i = 0; i < 66; i++) begin
      send_request(nfea_pkg::REQ_FREE, 17'd1, 16'(4 + 2 * i), 0);
    end
    drain();

    // empty table, then pool clipped at the top
    reg_write(nfea_pkg::REG_POOL_SIZE, 32'd0);
    send_request(nfea_pkg::REQ_ALLOC, 17'd1, 16'd0, 0);
    send_request(nfea_pkg::REQ_FREE, 17'd8, 16'd100, 0);
    send_request(nfea_pkg::REQ_ALLOC, 17'd8, 16'd0, 0);
    send_request(nfea_pkg::REQ_ALLOC, 17'd0, 16'd0, 0);
    drain();
    reg_write(nfea_pkg::REG_POOL_BASE, 32'hFFFF_FF00);
    reg_write(nfea_pkg::REG_POOL_SIZE, 32'hFFFF_FFFF);
    send_request(nfea_pkg::REQ_ALLOC, 17'd256, 16'd0, 0);
    send_request(nfea_pkg::REQ_FREE, 17'd256, 16'hFF00, 0);
    drain();

    // random phases over several pools, with one long result stall
    reg_write(nfea_pkg::REG_POOL_BASE, 32'd1000);
    reg_write(nfea_pkg::REG_POOL_SIZE, 32'd600);
    hold_off = 1;
    random_phase(120, 16'd1000, 600);
    drain();
    reg_write(nfea_pkg::REG_POOL_BASE, 32'd0);
    reg_write(nfea_pkg::REG_POOL_SIZE, 32'h10000);
    random_phase(120, 16'd0, 400);
    drain();
    reg_write(nfea_pkg::REG_POOL_BASE, 32'hFE00);
    reg_write(nfea_pkg::REG_POOL_SIZE, 32'd300);
    random_phase(120, 16'hFE00, 511);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
